// File: rtl/lapy_pkg.sv
// Shared types, constants and elaboration-time functions for the look-at pitch/yaw block.
`timescale 1ns / 1ps

package lapy_pkg;

    // Default pipeline configuration.
    localparam int CORDIC_STAGES_DEF   = 18;
    localparam int ANGLE_FRAC_BITS_DEF = 16;

    // Field and datapath widths.
    localparam int COORD_W   = 32;
    localparam int D_W       = COORD_W + 1;
    localparam int SCALE_SH  = 16;
    localparam int MAG_W     = D_W + SCALE_SH;
    localparam int VEC_W     = 54;
    localparam int ANG_W     = 34;
    localparam int ANG_Q     = 30;
    localparam int GAIN_W    = 31;
    localparam int PITCH_W   = 18;
    localparam int YAW_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int ATAN_N    = 32;
    localparam int ATAN_W    = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_Z = CFG_IDX_W'(2);

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    // Angles in Q30 radians.
    localparam ang_t HALF_PI_Q30 = ANG_W'(64'd1686629713);
    localparam ang_t PI_Q30      = ANG_W'(64'd3373259426);

    // Input and result transfers.
    typedef struct packed {
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
    } target_t;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch_angle;
        logic signed [YAW_W-1:0]   yaw_angle;
    } angles_t;

    // Special-case flags that ride alongside the vectors.
    typedef struct packed {
        logic dy_zero;
        logic dist_zero;
        logic dy_neg;
        logic dx_zero;
        logic dx_pos;
        logic dz_zero;
        logic dz_pos;
    } flags_t;

    // Front end output: CORDIC start vectors and the gain-scaled dy.
    typedef struct packed {
        vec_t   ax;
        vec_t   az;
        vec_t   yaw_x;
        vec_t   yaw_y;
        vec_t   yk;
        flags_t flags;
    } front_t;

    // Side data carried through the first and the second CORDIC bank.
    typedef struct packed {
        vec_t   yk;
        flags_t flags;
    } bank1_sb_t;

    typedef struct packed {
        ang_t   yaw_z;
        flags_t flags;
    } bank2_sb_t;

    // Arctangent of 2^-i in Q30.
    localparam logic [ATAN_W-1:0] ATAN_Q30 [ATAN_N] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    // Integer square root, used only for constants at elaboration.
    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        logic        started;
        rem     = n;
        res     = '0;
        b       = 64'd1 << 62;
        started = 1'b0;
        for (int j = 0; j < 32; j++)
        begin
            if (!started && (b > rem))
            begin
                b = b >> 2;
            end
            else
            begin
                started = 1'b1;
                if (rem >= res + b)
                begin
                    rem = rem - (res + b);
                    res = (res >> 1) + b;
                end
                else
                begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // Product of sqrt(1 + 2^-2i) over the stages, Q30.
    function automatic logic [63:0] cordic_gain(input int stages);
        logic [63:0] k;
        logic [63:0] sq;
        k = 64'd1 << ANG_Q;
        for (int i = 0; i < ATAN_N; i++)
        begin
            if (i < stages)
            begin
                sq = 64'd1 << 60;
                if (2 * i <= 60)
                begin
                    sq = sq + (64'd1 << (60 - 2 * i));
                end
                k = (k * isqrt64(sq)) >> ANG_Q;
            end
        end
        return k;
    endfunction

endpackage

// File: rtl/lapy_front.sv
// Front end: position registers, difference, special-case flags and gain-scaled dy.
`timescale 1ns / 1ps

module lapy_front #(
    parameter int CORDIC_STAGES = lapy_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [lapy_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lapy_pkg::COORD_W-1:0]     cfg_data,
    input  logic                             target_valid,
    output logic                             target_ready,
    input  lapy_pkg::target_t                target,
    output logic                             prep_valid,
    input  logic                             prep_ready,
    output lapy_pkg::front_t                 prep
);

    localparam int D_W     = lapy_pkg::D_W;
    localparam int VEC_W   = lapy_pkg::VEC_W;
    localparam int MAG_W   = lapy_pkg::MAG_W;
    localparam int SH      = lapy_pkg::SCALE_SH;
    localparam int GAIN_W  = lapy_pkg::GAIN_W;
    localparam int LO_W    = 20;
    localparam int HI_W    = MAG_W - LO_W;
    localparam int HI_SH   = lapy_pkg::ANG_Q - LO_W;
    localparam int HK_W    = HI_W + GAIN_W;
    localparam int LK_W    = LO_W + GAIN_W;
    localparam int YK_W    = HK_W - HI_SH + 1;
    localparam logic [63:0] GAIN_FULL = lapy_pkg::cordic_gain(CORDIC_STAGES);
    localparam logic [GAIN_W-1:0] GAIN_K = GAIN_FULL[GAIN_W-1:0];

    logic signed [lapy_pkg::COORD_W-1:0] position_x_reg;
    logic signed [lapy_pkg::COORD_W-1:0] position_y_reg;
    logic signed [lapy_pkg::COORD_W-1:0] position_z_reg;

    // Stage 1: difference.
    logic                  v1_reg;
    logic signed [D_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [D_W-1:0] dx_next, dy_next, dz_next;

    // Stage 2: magnitudes, yaw vector and flags.
    logic                v2_reg;
    lapy_pkg::vec_t      ax2_reg, az2_reg, yx2_reg, yy2_reg;
    logic [MAG_W-1:0]    ady2_reg;
    lapy_pkg::flags_t    flags2_reg;
    logic                none2_reg;
    lapy_pkg::vec_t      ax2_next, az2_next, yx2_next, yy2_next;
    logic [MAG_W-1:0]    ady2_next;
    lapy_pkg::flags_t    flags2_next;
    logic                none2_next;
    logic [D_W-1:0]      adx, ady, adz;
    lapy_pkg::vec_t      dxs, dzs;

    // Stage 3: partial products of dy and the gain.
    logic                v3_reg;
    lapy_pkg::vec_t      ax3_reg, az3_reg, yx3_reg, yy3_reg;
    lapy_pkg::flags_t    flags3_reg;
    logic [HK_W-1:0]     hk3_reg;
    logic [LK_W-1:0]     lk3_reg;
    logic [HK_W-1:0]     hk3_next;
    logic [LK_W-1:0]     lk3_next;

    // Stage 4: gain-scaled dy with its sign.
    logic                v4_reg;
    lapy_pkg::front_t    prep_reg;
    lapy_pkg::front_t    prep_next;
    logic [YK_W-1:0]     yk_mag;

    logic ld1, ld2, ld3, ld4;

    // Stall chain: a stage takes new data when it is empty or moves on.
    assign ld4          = !v4_reg || prep_ready;
    assign ld3          = !v3_reg || ld4;
    assign ld2          = !v2_reg || ld3;
    assign ld1          = !v1_reg || ld2;
    assign target_ready = ld1;
    assign prep_valid   = v4_reg;
    assign prep         = prep_reg;

    // Position registers, written by configuration transfers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_x_reg <= '0;
            position_y_reg <= '0;
            position_z_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lapy_pkg::REG_POSITION_X: position_x_reg <= cfg_data;
                lapy_pkg::REG_POSITION_Y: position_y_reg <= cfg_data;
                lapy_pkg::REG_POSITION_Z: position_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Exact difference in 33 bits.
    always_comb
    begin
        dx_next = {position_x_reg[31], position_x_reg} - {target.target_x[31], target.target_x};
        dy_next = {position_y_reg[31], position_y_reg} - {target.target_y[31], target.target_y};
        dz_next = {position_z_reg[31], position_z_reg} - {target.target_z[31], target.target_z};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (ld1)
        begin
            v1_reg <= target_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            dz_reg <= dz_next;
        end
    end

    // Absolute values, scaled vectors and the special-case flags.
    always_comb
    begin
        adx = dx_reg[D_W-1] ? D_W'(-dx_reg) : dx_reg;
        ady = dy_reg[D_W-1] ? D_W'(-dy_reg) : dy_reg;
        adz = dz_reg[D_W-1] ? D_W'(-dz_reg) : dz_reg;
        dxs = lapy_pkg::vec_t'(dx_reg) <<< SH;
        dzs = lapy_pkg::vec_t'(dz_reg) <<< SH;

        ax2_next  = lapy_pkg::vec_t'({{(VEC_W-MAG_W){1'b0}}, adx, {SH{1'b0}}});
        az2_next  = lapy_pkg::vec_t'({{(VEC_W-MAG_W){1'b0}}, adz, {SH{1'b0}}});
        ady2_next = {ady, {SH{1'b0}}};
        // The yaw vector is turned into the right half plane.
        yx2_next  = dz_reg[D_W-1] ? -dzs : dzs;
        yy2_next  = dz_reg[D_W-1] ? -dxs : dxs;

        flags2_next.dy_zero   = (dy_reg == '0);
        flags2_next.dist_zero = (dx_reg == '0) && (dz_reg == '0);
        flags2_next.dy_neg    = dy_reg[D_W-1];
        flags2_next.dx_zero   = (dx_reg == '0);
        flags2_next.dx_pos    = !dx_reg[D_W-1] && (dx_reg != '0);
        flags2_next.dz_zero   = (dz_reg == '0);
        flags2_next.dz_pos    = !dz_reg[D_W-1] && (dz_reg != '0);
        none2_next = (dx_reg == '0) && (dy_reg == '0) && (dz_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (ld2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            ax2_reg    <= ax2_next;
            az2_reg    <= az2_next;
            yx2_reg    <= yx2_next;
            yy2_reg    <= yy2_next;
            ady2_reg   <= ady2_next;
            flags2_reg <= flags2_next;
            none2_reg  <= none2_next;
        end
    end

    // Gain multiply split into a high and a low partial product.
    always_comb
    begin
        hk3_next = ady2_reg[MAG_W-1:LO_W] * GAIN_K;
        lk3_next = ady2_reg[LO_W-1:0] * GAIN_K;
    end

    // A target equal to the position is dropped here and gives no result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (ld3)
        begin
            v3_reg <= v2_reg && !none2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            ax3_reg    <= ax2_reg;
            az3_reg    <= az2_reg;
            yx3_reg    <= yx2_reg;
            yy3_reg    <= yy2_reg;
            flags3_reg <= flags2_reg;
            hk3_reg    <= hk3_next;
            lk3_reg    <= lk3_next;
        end
    end

    // Sum of the partial products, each truncated on its own, then the sign of dy.
    always_comb
    begin
        yk_mag = {1'b0, hk3_reg[HK_W-1:HI_SH]}
               + YK_W'(lk3_reg[LK_W-1:lapy_pkg::ANG_Q]);
        prep_next.ax    = ax3_reg;
        prep_next.az    = az3_reg;
        prep_next.yaw_x = yx3_reg;
        prep_next.yaw_y = yy3_reg;
        prep_next.yk    = flags3_reg.dy_neg
                        ? -lapy_pkg::vec_t'({{(VEC_W-YK_W){1'b0}}, yk_mag})
                        : lapy_pkg::vec_t'({{(VEC_W-YK_W){1'b0}}, yk_mag});
        prep_next.flags = flags3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (ld4)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            prep_reg <= prep_next;
        end
    end

endmodule

// File: rtl/lapy_cordic.sv
// Pipelined vectoring CORDIC, one register stage per rotation, with side data.
`timescale 1ns / 1ps

module lapy_cordic #(
    parameter int CORDIC_STAGES = lapy_pkg::CORDIC_STAGES_DEF,
    parameter int LANES         = 1,
    parameter int SB_W          = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  lapy_pkg::vec_t [LANES-1:0]       in_x,
    input  lapy_pkg::vec_t [LANES-1:0]       in_y,
    input  logic [SB_W-1:0]                  in_sb,
    output logic                             out_valid,
    input  logic                             out_ready,
    output lapy_pkg::vec_t [LANES-1:0]       out_x,
    output lapy_pkg::ang_t [LANES-1:0]       out_z,
    output logic [SB_W-1:0]                  out_sb
);

    localparam int VEC_W  = lapy_pkg::VEC_W;
    localparam int ANG_W  = lapy_pkg::ANG_W;
    localparam int ATAN_W = lapy_pkg::ATAN_W;

    logic                        valid_reg [CORDIC_STAGES];
    logic                        load      [CORDIC_STAGES+1];
    lapy_pkg::vec_t [LANES-1:0]  x_reg     [CORDIC_STAGES];
    lapy_pkg::vec_t [LANES-1:0]  y_reg     [CORDIC_STAGES];
    lapy_pkg::ang_t [LANES-1:0]  z_reg     [CORDIC_STAGES];
    logic [SB_W-1:0]             sb_reg    [CORDIC_STAGES];

    assign load[CORDIC_STAGES] = out_ready;
    assign in_ready            = load[0];
    assign out_valid           = valid_reg[CORDIC_STAGES-1];
    assign out_x               = x_reg[CORDIC_STAGES-1];
    assign out_z               = z_reg[CORDIC_STAGES-1];
    assign out_sb              = sb_reg[CORDIC_STAGES-1];

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        localparam lapy_pkg::ang_t ATAN_STEP =
            ANG_W'({{(ANG_W-ATAN_W){1'b0}}, lapy_pkg::ATAN_Q30[i]});

        logic                        valid_prev;
        lapy_pkg::vec_t [LANES-1:0]  x_prev, y_prev, x_next, y_next;
        lapy_pkg::ang_t [LANES-1:0]  z_prev, z_next;
        logic [SB_W-1:0]             sb_prev;

        if (i == 0)
        begin : g_first
            assign valid_prev = in_valid;
            assign x_prev     = in_x;
            assign y_prev     = in_y;
            assign z_prev     = '0;
            assign sb_prev    = in_sb;
        end
        else
        begin : g_rest
            assign valid_prev = valid_reg[i-1];
            assign x_prev     = x_reg[i-1];
            assign y_prev     = y_reg[i-1];
            assign z_prev     = z_reg[i-1];
            assign sb_prev    = sb_reg[i-1];
        end

        // The stage takes new data when it is empty or its content moves on.
        assign load[i] = !valid_reg[i] || load[i+1];

        // One rotation per lane, direction from the sign of y.
        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (!y_prev[l][VEC_W-1])
                begin
                    x_next[l] = x_prev[l] + ($signed(y_prev[l]) >>> i);
                    y_next[l] = y_prev[l] - ($signed(x_prev[l]) >>> i);
                    z_next[l] = z_prev[l] + ATAN_STEP;
                end
                else
                begin
                    x_next[l] = x_prev[l] - ($signed(y_prev[l]) >>> i);
                    y_next[l] = y_prev[l] + ($signed(x_prev[l]) >>> i);
                    z_next[l] = z_prev[l] - ATAN_STEP;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (load[i])
            begin
                valid_reg[i] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (load[i])
            begin
                x_reg[i]  <= x_next;
                y_reg[i]  <= y_next;
                z_reg[i]  <= z_next;
                sb_reg[i] <= sb_prev;
            end
        end
    end

endmodule

// File: rtl/lapy_back.sv
// Back end: special-case angle selection, pi offset, rounding and saturation.
`timescale 1ns / 1ps

module lapy_back #(
    parameter int ANGLE_FRAC_BITS = lapy_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_valid,
    output logic                  res_ready,
    input  lapy_pkg::ang_t        pitch_z,
    input  lapy_pkg::bank2_sb_t   res_sb,
    output logic                  angle_valid,
    input  logic                  angle_ready,
    output lapy_pkg::angles_t     angles
);

    localparam int ANG_W   = lapy_pkg::ANG_W;
    localparam int RW      = ANG_W + 1;
    localparam int RND_S   = lapy_pkg::ANG_Q - ANGLE_FRAC_BITS;
    localparam int PITCH_W = lapy_pkg::PITCH_W;
    localparam int YAW_W   = lapy_pkg::YAW_W;

    localparam logic signed [RW-1:0] RND_HALF = RW'(64'd1 << (RND_S - 1));
    localparam logic signed [RW-1:0] P_LIM    = RW'(64'd1 << (PITCH_W - 1));
    localparam logic signed [RW-1:0] P_MAX    = P_LIM - RW'(1);
    localparam logic signed [RW-1:0] P_MIN    = -P_LIM;
    localparam logic signed [RW-1:0] Y_LIM    = RW'(64'd1 << (YAW_W - 1));
    localparam logic signed [RW-1:0] Y_MAX    = Y_LIM - RW'(1);
    localparam logic signed [RW-1:0] Y_MIN    = -Y_LIM;

    logic              v1_reg;
    lapy_pkg::ang_t    pitch_q_reg, yaw_q_reg;
    lapy_pkg::ang_t    pitch_q_next, yaw_q_next, yaw_base;
    logic              angle_valid_reg;
    lapy_pkg::angles_t angles_reg;
    lapy_pkg::angles_t angles_next;
    logic signed [RW-1:0] pitch_sum, yaw_sum, pitch_sh, yaw_sh;
    logic ld1, ld2;

    assign ld2         = !angle_valid_reg || angle_ready;
    assign ld1         = !v1_reg || ld2;
    assign res_ready   = ld1;
    assign angle_valid = angle_valid_reg;
    assign angles      = angles_reg;

    // Exact angles for the degenerate vectors, pi added when dz is positive.
    always_comb
    begin
        if (res_sb.flags.dy_zero)
        begin
            pitch_q_next = '0;
        end
        else if (res_sb.flags.dist_zero)
        begin
            pitch_q_next = res_sb.flags.dy_neg ? -lapy_pkg::HALF_PI_Q30 : lapy_pkg::HALF_PI_Q30;
        end
        else
        begin
            pitch_q_next = pitch_z;
        end

        if (res_sb.flags.dx_zero)
        begin
            yaw_base = '0;
        end
        else if (res_sb.flags.dz_zero)
        begin
            yaw_base = res_sb.flags.dx_pos ? lapy_pkg::HALF_PI_Q30 : -lapy_pkg::HALF_PI_Q30;
        end
        else
        begin
            yaw_base = res_sb.yaw_z;
        end
        yaw_q_next = yaw_base + (res_sb.flags.dz_pos ? lapy_pkg::PI_Q30 : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (ld1)
        begin
            v1_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            pitch_q_reg <= pitch_q_next;
            yaw_q_reg   <= yaw_q_next;
        end
    end

    // Round half up to the output fraction, then clamp to the field range.
    always_comb
    begin
        pitch_sum = $signed({pitch_q_reg[ANG_W-1], pitch_q_reg}) + RND_HALF;
        yaw_sum   = $signed({yaw_q_reg[ANG_W-1], yaw_q_reg}) + RND_HALF;
        pitch_sh  = pitch_sum >>> RND_S;
        yaw_sh    = yaw_sum >>> RND_S;

        if (pitch_sh > P_MAX)
        begin
            angles_next.pitch_angle = P_MAX[PITCH_W-1:0];
        end
        else if (pitch_sh < P_MIN)
        begin
            angles_next.pitch_angle = P_MIN[PITCH_W-1:0];
        end
        else
        begin
            angles_next.pitch_angle = pitch_sh[PITCH_W-1:0];
        end

        if (yaw_sh > Y_MAX)
        begin
            angles_next.yaw_angle = Y_MAX[YAW_W-1:0];
        end
        else if (yaw_sh < Y_MIN)
        begin
            angles_next.yaw_angle = Y_MIN[YAW_W-1:0];
        end
        else
        begin
            angles_next.yaw_angle = yaw_sh[YAW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_valid_reg <= 1'b0;
        end
        else if (ld2)
        begin
            angle_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            angles_reg <= angles_next;
        end
    end

endmodule

// File: rtl/look_at_pitch_yaw.sv
// Look-at pitch/yaw top level: front end, two CORDIC banks and the back end.
// Throughput: one target per cycle unless angle_ready stalls the output, set by the
// one-rotation-per-stage CORDIC pipelines.
// A target equal to the position is accepted and produces no result.
// Reset clears every pipeline valid bit and sets the position registers to zero.
// The configuration port is always ready.
`timescale 1ns / 1ps

module look_at_pitch_yaw #(
    parameter int CORDIC_STAGES   = lapy_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = lapy_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lapy_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lapy_pkg::COORD_W-1:0]     cfg_data,
    input  logic                             target_valid,
    output logic                             target_ready,
    input  lapy_pkg::target_t                target,
    output logic                             angle_valid,
    input  logic                             angle_ready,
    output lapy_pkg::angles_t                angles
);

    localparam int SB1_W = $bits(lapy_pkg::bank1_sb_t);
    localparam int SB2_W = $bits(lapy_pkg::bank2_sb_t);

    logic                       prep_valid, prep_ready;
    lapy_pkg::front_t           prep;
    lapy_pkg::vec_t [1:0]       b1_x, b1_y, b1_out_x;
    lapy_pkg::ang_t [1:0]       b1_out_z;
    lapy_pkg::bank1_sb_t        b1_sb, b1_out_sb;
    logic                       b1_valid, b1_ready;
    lapy_pkg::vec_t [0:0]       b2_x, b2_y;
    lapy_pkg::ang_t [0:0]       b2_out_z;
    lapy_pkg::bank2_sb_t        b2_sb, b2_out_sb;
    logic                       b2_valid, b2_ready;

    assign cfg_ready = 1'b1;

    lapy_front #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .target_valid (target_valid),
        .target_ready (target_ready),
        .target       (target),
        .prep_valid   (prep_valid),
        .prep_ready   (prep_ready),
        .prep         (prep)
    );

    // First bank: horizontal distance on lane 0, yaw angle on lane 1.
    assign b1_x[0] = prep.ax;
    assign b1_y[0] = prep.az;
    assign b1_x[1] = prep.yaw_x;
    assign b1_y[1] = prep.yaw_y;
    assign b1_sb   = '{yk: prep.yk, flags: prep.flags};

    lapy_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .LANES         (2),
        .SB_W          (SB1_W)
    ) u_bank1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_x      (b1_x),
        .in_y      (b1_y),
        .in_sb     (b1_sb),
        .out_valid (b1_valid),
        .out_ready (b1_ready),
        .out_x     (b1_out_x),
        .out_z     (b1_out_z),
        .out_sb    (b1_out_sb)
    );

    // Second bank: pitch from the gain-scaled distance and dy.
    assign b2_x[0] = b1_out_x[0];
    assign b2_y[0] = b1_out_sb.yk;
    assign b2_sb   = '{yaw_z: b1_out_z[1], flags: b1_out_sb.flags};

    lapy_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .LANES         (1),
        .SB_W          (SB2_W)
    ) u_bank2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b1_valid),
        .in_ready  (b1_ready),
        .in_x      (b2_x),
        .in_y      (b2_y),
        .in_sb     (b2_sb),
        .out_valid (b2_valid),
        .out_ready (b2_ready),
        .out_x     (),
        .out_z     (b2_out_z),
        .out_sb    (b2_out_sb)
    );

    lapy_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (b2_valid),
        .res_ready   (b2_ready),
        .pitch_z     (b2_out_z[0]),
        .res_sb      (b2_out_sb),
        .angle_valid (angle_valid),
        .angle_ready (angle_ready),
        .angles      (angles)
    );

endmodule

// File: tb/tb_look_at_pitch_yaw.sv
// Self-checking testbench for the look-at pitch/yaw block, with its own angle predictor.
`timescale 1ns / 1ps

module tb_look_at_pitch_yaw;

    localparam int CFG_IDX_W     = lapy_pkg::CFG_IDX_W;
    localparam int COORD_W       = lapy_pkg::COORD_W;
    localparam int PITCH_W       = lapy_pkg::PITCH_W;
    localparam int YAW_W         = lapy_pkg::YAW_W;
    localparam int N_STAGES      = (lapy_pkg::CORDIC_STAGES_DEF > 32)
                                 ? 32 : lapy_pkg::CORDIC_STAGES_DEF;
    localparam int FRAC_BITS     = lapy_pkg::ANGLE_FRAC_BITS_DEF;
    localparam int PIPE_LATENCY  = 2 * lapy_pkg::CORDIC_STAGES_DEF + 6;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int MAX_REPORTS   = 40;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

    localparam logic [COORD_W-1:0] Q16_ONE   = 32'h0001_0000;
    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

    localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
    localparam longint HALF_TURN_Q30    = 64'sd3373259426;

    // Arctangent of 2^-i, radians in Q30.
    localparam longint ARCTAN_Q30 [0:31] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
        'h00000001, 'h00000000
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;
    logic                 target_valid;
    logic                 target_ready;
    lapy_pkg::target_t    target;
    logic                 angle_valid;
    logic                 angle_ready;
    lapy_pkg::angles_t    angles;

    // Predictor copy of the position registers and the CORDIC gain.
    longint               pos_x = 0;
    longint               pos_y = 0;
    longint               pos_z = 0;
    longint unsigned      cordic_k;

    lapy_pkg::angles_t    pending_angles[$];
    lapy_pkg::angles_t    predicted;
    lapy_pkg::angles_t    oldest;

    int                   targets_sent  = 0;
    int                   angles_checked = 0;
    int                   cfg_writes    = 0;
    int                   mismatch_cnt  = 0;
    int                   cycle_cnt     = 0;

    bit                   tx_idle_on   = 1'b0;
    bit                   rx_idle_on   = 1'b0;
    int                   rx_hold_left = 0;

    look_at_pitch_yaw DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .target_valid (target_valid),
        .target_ready (target_ready),
        .target       (target),
        .angle_valid  (angle_valid),
        .angle_ready  (angle_ready),
        .angles       (angles)
    );

    // 100 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Angle predictor
    // ------------------------------------------------------------------

    // Floor square root, one result bit at a time.
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
            begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Product of sqrt(1 + 2^-2i) over the stages in use, Q30.
    function automatic longint unsigned gain_product_q30();
        longint unsigned k;
        longint unsigned sq;
        k = 64'd1 << 30;
        for (int i = 0; i < N_STAGES; i++)
        begin
            sq = 64'd1 << 60;
            if (2 * i <= 60)
            begin
                sq = sq + (64'd1 << (60 - 2 * i));
            end
            k = (k * floor_sqrt(sq)) >> 30;
        end
        return k;
    endfunction

    // Scales a non-negative vector component by the gain, split so nothing overflows.
    function automatic longint scale_by_gain(input longint a);
        longint unsigned ua;
        longint unsigned hi;
        longint unsigned lo;
        ua = a;
        hi = ua >> 20;
        lo = ua & 64'hF_FFFF;
        return longint'(((hi * cordic_k) >> 10) + ((lo * cordic_k) >> 30));
    endfunction

    // Vectoring rotation: drives y to zero, returns the angle turned and the magnitude.
    function automatic longint vector_rotate(input longint xi, input longint yi,
                                             output longint mag);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = xi;
        y = yi;
        z = 0;
        for (int i = 0; i < N_STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_Q30[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_Q30[i];
            end
        end
        mag = x;
        return z;
    endfunction

    // Rounds a Q30 angle half up to the output fraction and saturates to w bits.
    function automatic longint round_angle(input longint q30, input int w);
        longint v;
        longint hi;
        longint lo;
        v = q30;
        if (FRAC_BITS < 30)
        begin
            v = (q30 + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        end
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -(longint'(1) <<< (w - 1));
        if (v > hi)
        begin
            v = hi;
        end
        if (v < lo)
        begin
            v = lo;
        end
        return v;
    endfunction

    // Pitch and yaw for one target; returns 0 when the target sits on the object.
    function automatic bit compute_angles(input lapy_pkg::target_t t,
                                          output lapy_pkg::angles_t a);
        longint dx;
        longint dy;
        longint dz;
        longint ax;
        longint az;
        longint ady;
        longint horiz_mag;
        longint yk;
        longint unused_mag;
        longint pitch;
        longint yaw;
        dx    = pos_x - longint'(t.target_x);
        dy    = pos_y - longint'(t.target_y);
        dz    = pos_z - longint'(t.target_z);
        pitch = 0;
        yaw   = 0;
        a     = '0;
        if (dx == 0 && dy == 0 && dz == 0)
        begin
            return 1'b0;
        end

        // Pitch: elevation over the horizontal distance.
        if (dy != 0)
        begin
            if (dx == 0 && dz == 0)
            begin
                pitch = (dy > 0) ? QUARTER_TURN_Q30 : -QUARTER_TURN_Q30;
            end
            else
            begin
                ax  = ((dx < 0) ? -dx : dx) * 65536;
                az  = ((dz < 0) ? -dz : dz) * 65536;
                ady = ((dy < 0) ? -dy : dy) * 65536;
                unused_mag = vector_rotate(ax, az, horiz_mag);
                yk = scale_by_gain(ady);
                if (dy < 0)
                begin
                    yk = -yk;
                end
                pitch = vector_rotate(horiz_mag, yk, unused_mag);
            end
        end

        // Yaw: heading in the x-z plane, turned by half a revolution when dz is positive.
        if (dx != 0)
        begin
            if (dz == 0)
            begin
                yaw = (dx > 0) ? QUARTER_TURN_Q30 : -QUARTER_TURN_Q30;
            end
            else if (dz > 0)
            begin
                yaw = vector_rotate(dz * 65536, dx * 65536, unused_mag);
            end
            else
            begin
                yaw = vector_rotate(-dz * 65536, -dx * 65536, unused_mag);
            end
        end
        if (dz > 0)
        begin
            yaw = yaw + HALF_TURN_Q30;
        end

        pitch = round_angle(pitch, PITCH_W);
        yaw   = round_angle(yaw, YAW_W);
        a.pitch_angle = pitch[PITCH_W-1:0];
        a.yaw_angle   = yaw[YAW_W-1:0];
        return 1'b1;
    endfunction

    initial
    begin
        cordic_k = gain_product_q30();
    end

    // ------------------------------------------------------------------
    // Monitors and checker
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
        begin
            $display("[%0t] %s", $time, what);
        end
    endtask

    // Track position writes as they are transferred.
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            cfg_writes++;
            case (cfg_index)
                lapy_pkg::REG_POSITION_X: pos_x = longint'($signed(cfg_data));
                lapy_pkg::REG_POSITION_Y: pos_y = longint'($signed(cfg_data));
                lapy_pkg::REG_POSITION_Z: pos_z = longint'($signed(cfg_data));
                default: ;
            endcase
        end
    end

    // Predict the angles for every target transfer.
    always @(posedge clk)
    begin
        if (rst_n && target_valid && target_ready)
        begin
            targets_sent++;
            if (compute_angles(target, predicted))
            begin
                pending_angles.push_back(predicted);
            end
        end
    end

    // Compare each angle transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && angle_valid && angle_ready)
        begin
            if (pending_angles.size() == 0)
            begin
                report_mismatch($sformatf("unexpected angles pitch=%0d yaw=%0d",
                                          angles.pitch_angle, angles.yaw_angle));
            end
            else
            begin
                oldest = pending_angles.pop_front();
                angles_checked++;
                if (angles.pitch_angle !== oldest.pitch_angle)
                begin
                    report_mismatch($sformatf("result %0d: pitch_angle got %0d, want %0d",
                                              angles_checked, angles.pitch_angle,
                                              oldest.pitch_angle));
                end
                if (angles.yaw_angle !== oldest.yaw_angle)
                begin
                    report_mismatch($sformatf("result %0d: yaw_angle got %0d, want %0d",
                                              angles_checked, angles.yaw_angle,
                                              oldest.yaw_angle));
                end
            end
        end
    end

    // Hard limit on run length.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_angles.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    // Angle receiver: a long hold when asked for, otherwise random stalls if enabled.
    initial
    begin : rx_drive
        int stall;
        stall = 0;
        angle_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                angle_ready <= 1'b0;
                rx_hold_left--;
            end
            else if (stall > 0)
            begin
                angle_ready <= 1'b0;
                stall--;
            end
            else if (rx_idle_on && $urandom_range(0, 99) < 20)
            begin
                angle_ready <= 1'b0;
                stall = pick_gap() - 1;
            end
            else
            begin
                angle_ready <= 1'b1;
            end
        end
    end

    // Offers one target and returns at the edge where it is transferred.
    task automatic send_target(input lapy_pkg::target_t t);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 99) < 30)
        begin
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            @(negedge clk);
            target_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        target_valid <= 1'b1;
        target       <= t;
        do @(posedge clk); while (!target_ready);
    endtask

    task automatic write_position(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [COORD_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_position(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                input logic [COORD_W-1:0] z);
        write_position(lapy_pkg::REG_POSITION_X, x);
        write_position(lapy_pkg::REG_POSITION_Y, y);
        write_position(lapy_pkg::REG_POSITION_Z, z);
    endtask

    // Stops offering targets and waits for every predicted result to arrive.
    task automatic wait_results_done();
        @(negedge clk);
        target_valid <= 1'b0;
        while (pending_angles.size() != 0) @(negedge clk);
    endtask

    // Targets on the object give no result, so allow the pipeline to empty as well.
    task automatic settle_for_config();
        wait_results_done();
        repeat (PIPE_LATENCY + 8) @(negedge clk);
    endtask

    function automatic lapy_pkg::target_t make_target(input logic [COORD_W-1:0] x,
                                                      input logic [COORD_W-1:0] y,
                                                      input logic [COORD_W-1:0] z);
        lapy_pkg::target_t t;
        t.target_x = x;
        t.target_y = y;
        t.target_z = z;
        return t;
    endfunction

    // A coordinate on, or close to, the given position component.
    function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] p);
        int sel;
        logic [COORD_W-1:0] off;
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            return p;
        end
        else if (sel < 6)
        begin
            off = $urandom_range(0, 8) - 4;
        end
        else if (sel < 8)
        begin
            off = ($urandom_range(0, 8) - 4) << 16;
        end
        else
        begin
            off = 32'($signed(20'($urandom)));
        end
        return p + off;
    endfunction

    function automatic logic [COORD_W-1:0] odd_coord(input logic [COORD_W-1:0] p);
        case ($urandom_range(0, 4))
            0: return p;
            1: return COORD_MAX;
            2: return COORD_MIN;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Random target: wide, near the object, on the object, or from a set of corner values.
    function automatic lapy_pkg::target_t random_target();
        int kind;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] pz;
        kind = $urandom_range(0, 99);
        px   = pos_x[COORD_W-1:0];
        py   = pos_y[COORD_W-1:0];
        pz   = pos_z[COORD_W-1:0];
        if (kind < 35)
        begin
            return make_target($urandom, $urandom, $urandom);
        end
        else if (kind < 80)
        begin
            return make_target(near_coord(px), near_coord(py), near_coord(pz));
        end
        else if (kind < 88)
        begin
            return make_target(px, py, pz);
        end
        return make_target(odd_coord(px), odd_coord(py), odd_coord(pz));
    endfunction

    function automatic logic [COORD_W-1:0] pick_position(input int phase);
        case (phase)
            0: return '0;
            1: return COORD_MAX;
            2: return COORD_MIN;
            3: return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
            4: return 32'($signed(20'($urandom)));
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Singular directions and extreme coordinates at three object positions.
    task automatic test_special_directions();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;

        // Object at the origin after reset.
        send_target(make_target('0, '0, '0));
        send_target(make_target('0, -Q16_ONE, '0));
        send_target(make_target('0, Q16_ONE, '0));
        send_target(make_target(Q16_ONE, '0, 2 * Q16_ONE));
        send_target(make_target('0, 5 * Q16_ONE, -3 * Q16_ONE));
        send_target(make_target(-Q16_ONE, '0, '0));
        send_target(make_target(Q16_ONE, Q16_ONE, '0));
        send_target(make_target(-Q16_ONE, -Q16_ONE, -Q16_ONE));
        send_target(make_target(Q16_ONE, -Q16_ONE, -Q16_ONE));
        send_target(make_target(32'd1, 32'd1, 32'd1));
        send_target(make_target(COORD_MAX, COORD_MAX, COORD_MAX));
        send_target(make_target(COORD_MIN, COORD_MIN, COORD_MIN));
        send_target(make_target(COORD_MAX, COORD_MIN, '0));
        settle_for_config();

        // Object at the positive corner; the unused register index must change nothing.
        set_position(COORD_MAX, COORD_MAX, COORD_MAX);
        write_position(REG_UNUSED, $urandom);
        send_target(make_target(COORD_MIN, COORD_MIN, COORD_MIN));
        send_target(make_target(COORD_MAX, COORD_MAX, COORD_MAX));
        send_target(make_target(COORD_MAX, COORD_MIN, COORD_MAX));
        settle_for_config();

        // Object at the negative corner.
        set_position(COORD_MIN, COORD_MIN, COORD_MIN);
        send_target(make_target(COORD_MAX, COORD_MAX, COORD_MAX));
        send_target(make_target(COORD_MIN, COORD_MAX, COORD_MIN));
        send_target(make_target(COORD_MAX, COORD_MIN, COORD_MIN));
        send_target(make_target('0, '0, COORD_MAX));
        settle_for_config();
    endtask

    // Random targets over a series of object positions, idling switched in and out.
    task automatic test_random_positions();
        for (int p = 0; p < 8; p++)
        begin
            tx_idle_on = (p % 3) != 0;
            rx_idle_on = (p % 4) != 1;
            set_position(pick_position(p), pick_position(p), pick_position(p));
            repeat (70) send_target(random_target());
            settle_for_config();
        end
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall its input.
    task automatic test_output_backpressure();
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b1;
        rx_hold_left = 300;
        repeat (80) send_target(random_target());
        wait_results_done();
    endtask

    // The sender pauses until every result has been delivered, then carries on.
    task automatic test_drain_pause();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (25) send_target(random_target());
        wait_results_done();
        repeat (25) send_target(random_target());
        wait_results_done();
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= lapy_pkg::REG_POSITION_X;
        cfg_data     <= '0;
        target_valid <= 1'b0;
        target       <= '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_special_directions();
        test_random_positions();
        test_output_backpressure();
        test_drain_pause();

        wait_results_done();
        repeat (PIPE_LATENCY + 8) @(posedge clk);

        $display("Run covered %0d targets, %0d angle results and %0d position writes.",
                 targets_sent, angles_checked, cfg_writes);
        $display("Included: singular directions, extreme positions, output stall, drain pause.");
        if (mismatch_cnt == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/lapy_pkg.sv
rtl/lapy_front.sv
rtl/lapy_cordic.sv
rtl/lapy_back.sv
rtl/look_at_pitch_yaw.sv
tb/tb_look_at_pitch_yaw.sv
